// ===== rtl/cnsf_pkg.sv =====
package cnsf_pkg;

  localparam int unsigned CFG_X_W   = 9;
  localparam int unsigned CFG_Y_W   = 7;
  localparam int unsigned CFG_Z_W   = 7;
  localparam int unsigned CFG_W     = 9;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CODE_W    = 2;
  localparam int unsigned TDATA_W   = 8;

  localparam int unsigned DEF_MAX_PLANES = 256;
  localparam int unsigned DEF_MAX_ROWS   = 64;
  localparam int unsigned DEF_MAX_COLS   = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_Z = 2'd2;

  localparam logic [CODE_W-1:0] CODE_CAVITY = 2'b01;
  localparam logic [CODE_W-1:0] CODE_PROTEIN = 2'b00;
  localparam logic [CODE_W-1:0] CODE_MEDIUM = 2'b11;

  localparam logic [1:0] FIFO_EMPTY = 2'd0;
  localparam logic [1:0] FIFO_ONE   = 2'd1;
  localparam logic [1:0] FIFO_FULL  = 2'd2;

  // raw voxel pair: code at this index and at the one before it
  typedef struct packed {
    logic [CODE_W-1:0] cur;
    logic [CODE_W-1:0] prev;
  } raw_pair_t;

  typedef struct packed {
    logic              done;
    logic [CODE_W-1:0] code;
  } out_word_t;

  function automatic logic is_contact(input logic [CODE_W-1:0] c);
    is_contact = (c == CODE_PROTEIN) || (c == CODE_MEDIUM);
  endfunction

endpackage

// ===== rtl/cavity_noise_stencil_filter.sv =====
// Cavity noise stencil filter.
// Input stream (s_axis): one word per voxel of a grid_x * grid_y * grid_z grid in
// raster order, z innermost. tuser = 0 pushes the voxel code in tdata[1:0]
// (1 cavity, 0 protein, -1 medium); tuser = 1 is a drain word that flushes one
// pending voxel once the whole grid has arrived.
// Output stream (m_axis): decided voxel codes in raster order, tlast on the final
// voxel of the grid. An interior cavity whose six neighbors are all protein or
// medium comes out as medium.
// Throughput: one word per cycle on both sides unless the output buffer is full.
// A voxel is decided when its x+1 neighbor is pushed, so outputs trail inputs by one
// plane (grid_y * grid_z words); the result is registered in the output buffer before
// it shows on m_axis. The last plane is flushed by grid_y * grid_z drain words.
// The rate is set by the two dual-read windows (raw codes and decided codes),
// each read once a cycle for the next voxel to decide.
// Reset or a grid_x, grid_y or grid_z write restarts the grid; the windows need no clearing.
// A two-word output buffer keeps s_axis ready while one result waits; when the
// receiver stalls and the buffer is full, s_axis_tready_o drops.
// Config writes must happen while the stream is idle.
module cavity_noise_stencil_filter
  import cnsf_pkg::*;
#(
  parameter int unsigned MAX_PLANES = DEF_MAX_PLANES,
  parameter int unsigned MAX_ROWS   = DEF_MAX_ROWS,
  parameter int unsigned MAX_COLS   = DEF_MAX_COLS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [TDATA_W-1:0]   s_axis_tdata_i,   // [1:0] voxel_value, rest zero
  input  logic                 s_axis_tuser_i,   // [0] command
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [TDATA_W-1:0]   m_axis_tdata_o,   // [1:0] filtered_value, rest zero
  output logic                 m_axis_tlast_o
);

  localparam int unsigned NXW   = $clog2(MAX_PLANES + 1);
  localparam int unsigned NYW   = $clog2(MAX_ROWS + 1);
  localparam int unsigned NZW   = $clog2(MAX_COLS + 1);
  localparam int unsigned CXW   = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
  localparam int unsigned CYW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CZW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned PLW   = $clog2(MAX_ROWS * MAX_COLS + 1);
  localparam int unsigned AW    = $clog2(MAX_ROWS * MAX_COLS + 2);
  localparam int unsigned DEPTH = 1 << AW;

  logic [CFG_X_W-1:0] cfg_x_q;
  logic [CFG_Y_W-1:0] cfg_y_q;
  logic [CFG_Z_W-1:0] cfg_z_q;
  logic [NXW-1:0]     nx;
  logic [NYW-1:0]     ny;
  logic [NZW-1:0]     nz;
  logic [PLW-1:0]     plane_d, plane_q;

  logic [AW-1:0]  r_ptr_q, e_ptr_q, e_ptr_d, pend;
  logic [CXW-1:0] cx_q, cx_d, rx_q, rx_d;
  logic [CYW-1:0] cy_q, cy_d, ry_q, ry_d;
  logic [CZW-1:0] cz_q, cz_d, rz_q, rz_d;
  logic           rdone_q;

  logic s_fire, cmd_drain, push_ok, emit_push, emit_drain, emit, pop;
  logic last_c, last_d, rlast, restart, interior, all_contact;

  logic [CODE_W-1:0] in_code, prev_in_q, center, dec, dec_prev_q;

  raw_pair_t         r_mem [DEPTH];
  logic [CODE_W-1:0] d_mem [DEPTH];
  raw_pair_t         r_wr, rd_a_q, rd_b_q;
  logic [AW-1:0]     ra_addr, rb_addr, da_addr, db_addr;
  logic [CODE_W-1:0] rd_dp_q, rd_dz_q;

  logic [1:0] cnt_q;
  out_word_t  slot0_q, slot1_q, new_word;

  // effective dimensions
  always_comb begin
    if (cfg_x_q == '0) begin
      nx = NXW'(1);
    end else if (32'(cfg_x_q) > MAX_PLANES) begin
      nx = NXW'(MAX_PLANES);
    end else begin
      nx = NXW'(cfg_x_q);
    end
    if (cfg_y_q == '0) begin
      ny = NYW'(1);
    end else if (32'(cfg_y_q) > MAX_ROWS) begin
      ny = NYW'(MAX_ROWS);
    end else begin
      ny = NYW'(cfg_y_q);
    end
    if (cfg_z_q == '0) begin
      nz = NZW'(1);
    end else if (32'(cfg_z_q) > MAX_COLS) begin
      nz = NZW'(MAX_COLS);
    end else begin
      nz = NZW'(cfg_z_q);
    end
  end

  assign plane_d = PLW'(ny) * PLW'(nz);

  assign in_code    = s_axis_tdata_i[CODE_W-1:0];
  assign cmd_drain  = s_axis_tuser_i;
  assign s_fire     = s_axis_tvalid_i && s_axis_tready_o;
  assign pend       = r_ptr_q - e_ptr_q;
  assign push_ok    = s_fire && !cmd_drain && !rdone_q;
  assign emit_push  = push_ok && ((pend + AW'(1)) > AW'(plane_q));
  assign emit_drain = s_fire && cmd_drain && rdone_q && (pend != '0);
  assign emit       = emit_push || emit_drain;

  assign last_c = (NXW'(cx_q) + NXW'(1) == nx) && (NYW'(cy_q) + NYW'(1) == ny) &&
                  (NZW'(cz_q) + NZW'(1) == nz);
  assign rlast  = (NXW'(rx_q) + NXW'(1) == nx) && (NYW'(ry_q) + NYW'(1) == ny) &&
                  (NZW'(rz_q) + NZW'(1) == nz);
  assign restart = cfg_we_i || (emit && last_c);

  // next center and next receive position
  always_comb begin
    cx_d = cx_q;
    cy_d = cy_q;
    cz_d = cz_q;
    e_ptr_d = e_ptr_q;
    if (restart) begin
      cx_d = '0;
      cy_d = '0;
      cz_d = '0;
      e_ptr_d = '0;
    end else if (emit) begin
      e_ptr_d = e_ptr_q + AW'(1);
      if (NZW'(cz_q) + NZW'(1) >= nz) begin
        cz_d = '0;
        if (NYW'(cy_q) + NYW'(1) >= ny) begin
          cy_d = '0;
          cx_d = cx_q + CXW'(1);
        end else begin
          cy_d = cy_q + CYW'(1);
        end
      end else begin
        cz_d = cz_q + CZW'(1);
      end
    end
    rx_d = rx_q;
    ry_d = ry_q;
    rz_d = rz_q;
    if (restart) begin
      rx_d = '0;
      ry_d = '0;
      rz_d = '0;
    end else if (push_ok && !rlast) begin
      if (NZW'(rz_q) + NZW'(1) >= nz) begin
        rz_d = '0;
        if (NYW'(ry_q) + NYW'(1) >= ny) begin
          ry_d = '0;
          rx_d = rx_q + CXW'(1);
        end else begin
          ry_d = ry_q + CYW'(1);
        end
      end else begin
        rz_d = rz_q + CZW'(1);
      end
    end
  end

  assign last_d = (NXW'(cx_d) + NXW'(1) == nx) && (NYW'(cy_d) + NYW'(1) == ny) &&
                  (NZW'(cz_d) + NZW'(1) == nz);

  assign ra_addr = e_ptr_d + AW'(1);
  assign rb_addr = last_d ? e_ptr_d : e_ptr_d + AW'(nz);
  assign da_addr = e_ptr_d - AW'(plane_q);
  assign db_addr = e_ptr_d - AW'(nz);
  assign r_wr    = '{cur: in_code, prev: prev_in_q};

  // raw window, forwarded on a same-cycle push
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      r_mem[r_ptr_q] <= r_wr;
    end
    rd_a_q <= (push_ok && (ra_addr == r_ptr_q)) ? r_wr : r_mem[ra_addr];
    rd_b_q <= (push_ok && (rb_addr == r_ptr_q)) ? r_wr : r_mem[rb_addr];
  end

  // decided window
  always_ff @(posedge clk_i) begin
    if (emit) begin
      d_mem[e_ptr_q] <= dec;
    end
    rd_dp_q <= d_mem[da_addr];
    rd_dz_q <= d_mem[db_addr];
  end

  always_comb begin
    if (last_c) begin
      center = rd_b_q.cur;
    end else if (plane_q == PLW'(1)) begin
      center = prev_in_q;
    end else begin
      center = rd_a_q.prev;
    end
    interior = (cx_q != '0) && (NXW'(cx_q) + NXW'(1) < nx) &&
               (cy_q != '0) && (NYW'(cy_q) + NYW'(1) < ny) &&
               (cz_q != '0) && (NZW'(cz_q) + NZW'(1) < nz);
    all_contact = is_contact(rd_dp_q) && is_contact(in_code) &&
                  is_contact(rd_dz_q) && is_contact(rd_b_q.cur) &&
                  is_contact(dec_prev_q) && is_contact(rd_a_q.cur);
    dec = (center == CODE_CAVITY && interior && all_contact) ? CODE_MEDIUM : center;
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      prev_in_q <= in_code;
    end
    if (emit) begin
      dec_prev_q <= dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_x_q <= CFG_X_W'(1);
      cfg_y_q <= CFG_Y_W'(1);
      cfg_z_q <= CFG_Z_W'(1);
      plane_q <= PLW'(1);
      r_ptr_q <= '0;
      e_ptr_q <= '0;
      rdone_q <= 1'b0;
      cx_q    <= '0;
      cy_q    <= '0;
      cz_q    <= '0;
      rx_q    <= '0;
      ry_q    <= '0;
      rz_q    <= '0;
    end else begin
      plane_q <= plane_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_GRID_X: cfg_x_q <= cfg_data_i[CFG_X_W-1:0];
          CFG_GRID_Y: cfg_y_q <= cfg_data_i[CFG_Y_W-1:0];
          CFG_GRID_Z: cfg_z_q <= cfg_data_i[CFG_Z_W-1:0];
          default: ;
        endcase
      end
      if (cfg_we_i && (cfg_idx_i != CFG_GRID_X) && (cfg_idx_i != CFG_GRID_Y) &&
          (cfg_idx_i != CFG_GRID_Z)) begin
        // write beyond the register list: no restart
        e_ptr_q <= e_ptr_q;
      end else begin
        e_ptr_q <= e_ptr_d;
        cx_q    <= cx_d;
        cy_q    <= cy_d;
        cz_q    <= cz_d;
        rx_q    <= rx_d;
        ry_q    <= ry_d;
        rz_q    <= rz_d;
        if (restart) begin
          r_ptr_q <= '0;
          rdone_q <= 1'b0;
        end else if (push_ok) begin
          r_ptr_q <= r_ptr_q + AW'(1);
          if (rlast) begin
            rdone_q <= 1'b1;
          end
        end
      end
    end
  end

  // two-word output buffer
  assign new_word = '{done: last_c, code: dec};
  assign pop      = m_axis_tvalid_o && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= FIFO_EMPTY;
    end else begin
      case ({emit, pop})
        2'b10: cnt_q <= cnt_q + 2'd1;
        2'b01: cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case ({emit, pop})
      2'b10: begin
        if (cnt_q == FIFO_EMPTY) begin
          slot0_q <= new_word;
        end else begin
          slot1_q <= new_word;
        end
      end
      2'b01: slot0_q <= slot1_q;
      2'b11: begin
        if (cnt_q == FIFO_ONE) begin
          slot0_q <= new_word;
        end else begin
          slot0_q <= slot1_q;
          slot1_q <= new_word;
        end
      end
      default: ;
    endcase
  end

  assign s_axis_tready_o = (cnt_q != FIFO_FULL);
  assign m_axis_tvalid_o = (cnt_q != FIFO_EMPTY);
  assign m_axis_tdata_o  = {{(TDATA_W - CODE_W){1'b0}}, slot0_q.code};
  assign m_axis_tlast_o  = slot0_q.done;

  a_pend_le_plane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend <= AW'(plane_q))
    else $error("pending voxels exceed one plane");

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && last_c) |=> (e_ptr_q == '0 && r_ptr_q == '0 && !rdone_q))
    else $error("grid did not restart after final voxel");

  a_push_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && !cmd_drain && rdone_q && !cfg_we_i) |=> $stable(r_ptr_q))
    else $error("push after full grid was taken");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(emit && !pop && cnt_q == FIFO_FULL))
    else $error("output buffer overflow");

endmodule
